[src/rcst_pkg.sv]
`timescale 1ns / 1ps

package rcst_pkg;

    // Default geometry of the table
    localparam int MAX_SLOTS_DEF  = 64;
    localparam int COUNT_BITS_DEF = 16;

    // Fixed field widths of the channels
    localparam int ACTIVE_W   = 7;
    localparam int SLOT_ID_W  = 6;
    localparam int COUNT_W    = 16;

    localparam logic [ACTIVE_W-1:0] ACTIVE_SLOTS_RESET = 7'd64;

    typedef enum logic [1:0] {
        CMD_ALLOC   = 2'd0,
        CMD_ACQUIRE = 2'd1,
        CMD_RELEASE = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_FULL    = 2'd1,
        STAT_BAD_ACQ = 2'd2,
        STAT_BAD_REL = 2'd3
    } status_t;

    typedef struct packed {
        cmd_t                 command;
        logic [SLOT_ID_W-1:0] slot_id;
        logic                 auto_free;
    } req_t;

    typedef struct packed {
        status_t              status;
        logic [SLOT_ID_W-1:0] granted_slot;
        logic [COUNT_W-1:0]   count_after;
        logic                 slot_freed;
    } rsp_t;

endpackage

[src/rcst_ram.sv]
`timescale 1ns / 1ps

module rcst_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[src/refcounted_slot_table.sv]
`timescale 1ns / 1ps
// Flow: an accepted command reads its slot entry, is decided and written back in the check
// state, and its result is loaded into the output register from the response state; the unused
// command, an out-of-range id or allocate with a zero window skip the check; allocate probes slots
// in order from slot 0. Only one command is in flight at a time; a result held on the output
// stalls the input. Reset: synchronous, active low; afterwards a clearing pass zeroes every
// slot while s_ready stays low. Configuration writes are taken at any time.

module refcounted_slot_table #(
    parameter int MAX_SLOTS  = rcst_pkg::MAX_SLOTS_DEF,
    parameter int COUNT_BITS = rcst_pkg::COUNT_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // configuration: active slot count
    input  logic                               cfg_we,
    input  logic [rcst_pkg::ACTIVE_W-1:0]      cfg_wdata,
    // command channel
    input  logic                               s_valid,
    output logic                               s_ready,
    input  rcst_pkg::req_t                     s_data,
    // result channel
    output logic                               m_valid,
    input  logic                               m_ready,
    output rcst_pkg::rsp_t                     m_data
);

    localparam int AW = $clog2(MAX_SLOTS);
    localparam int EW = COUNT_BITS + 2;   // occupied, auto-free, count
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,   // sweep the slot memory after reset
        ST_IDLE  = 4'b0010,   // wait for a command transfer
        ST_CHECK = 4'b0100,   // entry read back: decide and write
        ST_RESP  = 4'b1000    // hand the result to the output register
    } state_t;

    state_t                       state_reg, state_next;
    logic [AW-1:0]                addr_reg, addr_next;
    logic [rcst_pkg::ACTIVE_W-1:0] active_reg;
    rcst_pkg::req_t               req_reg, req_next;
    rcst_pkg::rsp_t               res_reg, res_next;
    logic                         m_valid_reg, m_valid_next;
    rcst_pkg::rsp_t               m_data_reg, m_data_next;

    // slot memory port signals
    logic                         ram_we;
    logic [AW-1:0]                ram_waddr;
    logic [EW-1:0]                ram_wdata;
    logic [AW-1:0]                ram_raddr;
    logic [EW-1:0]                ram_rdata;

    // fields of the entry read back
    logic                         ent_occ;
    logic                         ent_af;
    logic [COUNT_BITS-1:0]        ent_cnt;
    logic [COUNT_BITS-1:0]        cnt_inc;
    logic [COUNT_BITS-1:0]        cnt_dec;
    logic [AW:0]                  scan_next;
    logic                         scan_more;
    logic                         id_in_range;

    rcst_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_SLOTS)
    ) u_slots (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign ent_occ = ram_rdata[EW-1];
    assign ent_af  = ram_rdata[EW-2];
    assign ent_cnt = ram_rdata[COUNT_BITS-1:0];

    // saturate at the top, hold at zero at the bottom
    assign cnt_inc = (ent_cnt == COUNT_MAX) ? ent_cnt : ent_cnt + 1'b1;
    assign cnt_dec = (ent_cnt == '0) ? ent_cnt : ent_cnt - 1'b1;

    // allocation search stops at min(active slots, MAX_SLOTS)
    assign scan_next = {1'b0, addr_reg} + 1'b1;
    assign scan_more = (32'(scan_next) < 32'(active_reg)) && (32'(scan_next) < MAX_SLOTS);

    assign id_in_range = 32'(s_data.slot_id) < MAX_SLOTS;

    always_comb begin
        state_next   = state_reg;
        addr_next    = addr_reg;
        req_next     = req_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        ram_we       = 1'b0;
        ram_waddr    = addr_reg;
        ram_wdata    = '0;
        ram_raddr    = addr_reg;

        unique case (state_reg)
            ST_CLEAR: begin
                // zero one entry per cycle
                ram_we = 1'b1;
                if (addr_reg == AW'(MAX_SLOTS - 1)) begin
                    addr_next  = '0;
                    state_next = ST_IDLE;
                end else begin
                    addr_next = addr_reg + 1'b1;
                end
            end

            ST_IDLE: begin
                if (s_valid) begin
                    req_next = s_data;
                    res_next = '0;
                    unique case (s_data.command)
                        rcst_pkg::CMD_ALLOC: begin
                            // start the scan at slot 0
                            addr_next = '0;
                            ram_raddr = '0;
                            if (active_reg != '0) begin
                                state_next = ST_CHECK;
                            end else begin
                                res_next.status = rcst_pkg::STAT_FULL;
                                state_next      = ST_RESP;
                            end
                        end
                        rcst_pkg::CMD_ACQUIRE, rcst_pkg::CMD_RELEASE: begin
                            addr_next = AW'(s_data.slot_id);
                            ram_raddr = AW'(s_data.slot_id);
                            if (id_in_range) begin
                                state_next = ST_CHECK;
                            end else begin
                                res_next.status = (s_data.command == rcst_pkg::CMD_ACQUIRE) ?
                                                  rcst_pkg::STAT_BAD_ACQ :
                                                  rcst_pkg::STAT_BAD_REL;
                                res_next.granted_slot = s_data.slot_id;
                                state_next            = ST_RESP;
                            end
                        end
                        default: begin
                            // unused command: no change, all-zero result
                            state_next = ST_RESP;
                        end
                    endcase
                end
            end

            ST_CHECK: begin
                unique case (req_reg.command)
                    rcst_pkg::CMD_ALLOC: begin
                        if (!ent_occ) begin
                            ram_we    = 1'b1;
                            ram_wdata = {1'b1, req_reg.auto_free, COUNT_BITS'(1)};
                            res_next.status       = rcst_pkg::STAT_OK;
                            res_next.granted_slot = rcst_pkg::SLOT_ID_W'(addr_reg);
                            res_next.count_after  = rcst_pkg::COUNT_W'(1);
                            res_next.slot_freed   = 1'b0;
                            state_next            = ST_RESP;
                        end else if (scan_more) begin
                            // advance the probe; read the next entry
                            addr_next = AW'(scan_next);
                            ram_raddr = AW'(scan_next);
                        end else begin
                            res_next   = '0;
                            res_next.status = rcst_pkg::STAT_FULL;
                            state_next = ST_RESP;
                        end
                    end
                    rcst_pkg::CMD_ACQUIRE: begin
                        res_next.granted_slot = req_reg.slot_id;
                        if (!ent_occ) begin
                            res_next.status = rcst_pkg::STAT_BAD_ACQ;
                        end else begin
                            ram_we    = 1'b1;
                            ram_wdata = {1'b1, ent_af, cnt_inc};
                            res_next.status      = rcst_pkg::STAT_OK;
                            res_next.count_after = rcst_pkg::COUNT_W'(cnt_inc);
                        end
                        state_next = ST_RESP;
                    end
                    rcst_pkg::CMD_RELEASE: begin
                        res_next.granted_slot = req_reg.slot_id;
                        if (!ent_occ) begin
                            res_next.status = rcst_pkg::STAT_BAD_REL;
                        end else if (cnt_dec == '0 && ent_af) begin
                            // last reference gone: free the slot
                            ram_we    = 1'b1;
                            ram_wdata = '0;
                            res_next.status     = rcst_pkg::STAT_OK;
                            res_next.slot_freed = 1'b1;
                        end else begin
                            ram_we    = 1'b1;
                            ram_wdata = {1'b1, ent_af, cnt_dec};
                            res_next.status      = rcst_pkg::STAT_OK;
                            res_next.count_after = rcst_pkg::COUNT_W'(cnt_dec);
                        end
                        state_next = ST_RESP;
                    end
                    default: begin
                        state_next = ST_RESP;
                    end
                endcase
            end

            ST_RESP: begin
                // load the output register once it is free or being drained
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            addr_reg    <= '0;
            active_reg  <= rcst_pkg::ACTIVE_SLOTS_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            addr_reg    <= addr_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                active_reg <= cfg_wdata;
            end
        end
    end

    // payload: no reset
    always_ff @(posedge aclk) begin
        req_reg    <= req_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // one command at a time: no second transfer right after one
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("command accepted back to back");

    // the slot memory is never written while waiting for a command
    a_no_idle_write: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE |-> !ram_we)
        else $error("slot write while idle");

    // a full table reports slot 0 with count 0 and nothing freed
    a_full_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == rcst_pkg::STAT_FULL |->
            m_data.granted_slot == '0 && m_data.count_after == '0 && !m_data.slot_freed)
        else $error("table full result carries data");

    // a freed slot always ends with count 0 and status ok
    a_freed_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.slot_freed |->
            m_data.count_after == '0 && m_data.status == rcst_pkg::STAT_OK)
        else $error("freed slot with nonzero count");

    // a result is loaded only out of the response state
    a_load_from_resp: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg) == ST_RESP)
        else $error("result loaded outside response state");

endmodule

[tb/sv/refcounted_slot_table_tb.sv]
`timescale 1ns / 1ps

module refcounted_slot_table_tb;

    localparam int MAX_SLOTS    = rcst_pkg::MAX_SLOTS_DEF;
    localparam int SLOT_W       = rcst_pkg::SLOT_ID_W;
    localparam int CNT_W        = rcst_pkg::COUNT_W;
    localparam int ACT_W        = rcst_pkg::ACTIVE_W;
    localparam int RESET_CYCLES = 12;
    localparam int TX_IDLE_PCT  = 24;
    localparam int RX_IDLE_PCT  = 24;
    localparam int HOLD_CYCLES  = 300;
    // Worst case between transfers: a long result hold plus a full allocate search.
    localparam int STALL_LIMIT  = 3000;
    // Settle past the longest allocate search.
    localparam int END_SETTLE   = MAX_SLOTS + 16;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 115;
    localparam int BURST_ITEMS  = 40;
    localparam int MAX_REPORTS  = 40;

    // Command code that the block must answer with an all-zero result.
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam logic [CNT_W-1:0] COUNT_MAX = '1;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [ACT_W-1:0]      cfg_wdata = '0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    rcst_pkg::req_t        s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    rcst_pkg::rsp_t        m_data;

    refcounted_slot_table u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // Shadow copy of the slot table, advanced on every accepted command.
    logic                  slot_busy  [MAX_SLOTS];
    logic                  slot_auto  [MAX_SLOTS];
    logic [CNT_W-1:0]      slot_count [MAX_SLOTS];
    logic [ACT_W-1:0]      active_slots;

    rcst_pkg::rsp_t        pending_rsp_q[$];
    rcst_pkg::rsp_t        last_predicted;
    rcst_pkg::rsp_t        want;

    int                    mismatch_count = 0;
    int                    reports_left   = MAX_REPORTS;
    int                    quiet_cycles   = 0;
    int                    rx_hold_req    = 0;
    int                    rx_hold_left   = 0;
    bit                    tx_idle_en     = 1'b1;
    bit                    rx_idle_en     = 1'b1;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Table update for one command: returns the result the block owes.
    // ------------------------------------------------------------------
    function automatic rcst_pkg::rsp_t table_apply(input rcst_pkg::req_t r);
        rcst_pkg::rsp_t res;
        int             lim;
        bit             found;
        res   = '0;
        found = 1'b0;
        case (r.command)
            rcst_pkg::CMD_ALLOC: begin
                // Search only the active window, clipped to the physical table.
                lim = (active_slots < MAX_SLOTS) ? int'(active_slots) : MAX_SLOTS;
                res.status = rcst_pkg::STAT_FULL;
                for (int i = 0; i < lim && !found; i++) begin
                    if (!slot_busy[i]) begin
                        found            = 1'b1;
                        slot_busy[i]     = 1'b1;
                        slot_auto[i]     = r.auto_free;
                        slot_count[i]    = CNT_W'(1);
                        res.status       = rcst_pkg::STAT_OK;
                        res.granted_slot = SLOT_W'(i);
                        res.count_after  = CNT_W'(1);
                    end
                end
            end
            rcst_pkg::CMD_ACQUIRE: begin
                res.granted_slot = r.slot_id;
                if (!slot_busy[r.slot_id]) begin
                    res.status = rcst_pkg::STAT_BAD_ACQ;
                end else begin
                    // Saturate rather than wrap.
                    if (slot_count[r.slot_id] != COUNT_MAX)
                        slot_count[r.slot_id] = slot_count[r.slot_id] + 1'b1;
                    res.count_after = slot_count[r.slot_id];
                end
            end
            rcst_pkg::CMD_RELEASE: begin
                res.granted_slot = r.slot_id;
                if (!slot_busy[r.slot_id]) begin
                    res.status = rcst_pkg::STAT_BAD_REL;
                end else begin
                    if (slot_count[r.slot_id] != '0)
                        slot_count[r.slot_id] = slot_count[r.slot_id] - 1'b1;
                    // Free only at zero and only when the slot was marked auto-release.
                    if (slot_count[r.slot_id] == '0 && slot_auto[r.slot_id]) begin
                        slot_busy[r.slot_id] = 1'b0;
                        slot_auto[r.slot_id] = 1'b0;
                        res.slot_freed       = 1'b1;
                    end else begin
                        res.count_after = slot_count[r.slot_id];
                    end
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Command channel: offer one command, hold it until the transfer.
    // ------------------------------------------------------------------
    task automatic send_cmd(input rcst_pkg::cmd_t c, input logic [SLOT_W-1:0] id,
                            input logic af);
        rcst_pkg::req_t r;
        r.command   = c;
        r.slot_id   = id;
        r.auto_free = af;
        // Drop valid for a random gap; otherwise keep it high straight into the next command.
        if (tx_idle_en && $urandom_range(99) < TX_IDLE_PCT) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < TX_IDLE_PCT);
        end
        s_valid <= 1'b1;
        s_data  <= r;
        do @(posedge aclk); while (!s_ready);
        last_predicted = table_apply(r);
        pending_rsp_q.push_back(last_predicted);
    endtask

    // Drop valid and hold until every owed result has arrived.
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_rsp_q.size() != 0) @(posedge aclk);
    endtask

    task automatic set_active(input logic [ACT_W-1:0] v);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we       <= 1'b0;
        active_slots = v;
    endtask

    // Mostly well-formed traffic: acquire and release aim at live slots most of the time.
    task automatic send_random_cmd();
        int                   busy_ids[$];
        int                   roll;
        rcst_pkg::cmd_t       c;
        logic [SLOT_W-1:0]    id;
        for (int i = 0; i < MAX_SLOTS; i++)
            if (slot_busy[i]) busy_ids.push_back(i);
        roll = $urandom_range(99);
        if (roll < 30)      c = rcst_pkg::CMD_ALLOC;
        else if (roll < 62) c = rcst_pkg::CMD_ACQUIRE;
        else if (roll < 96) c = rcst_pkg::CMD_RELEASE;
        else                c = rcst_pkg::cmd_t'(CMD_UNUSED);
        id = SLOT_W'($urandom_range(MAX_SLOTS - 1));
        if (c != rcst_pkg::CMD_ALLOC && busy_ids.size() != 0 && $urandom_range(99) < 85)
            id = SLOT_W'(busy_ids[$urandom_range(busy_ids.size() - 1)]);
        send_cmd(c, id, $urandom_range(99) < 90);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Basic lifecycle from reset: allocate, acquire, release down to zero, bad ids,
    // release at zero, freeing, and the unused command.
    task automatic test_slot_lifecycle();
        send_cmd(rcst_pkg::CMD_ALLOC,   6'd0,  1'b0);   // slot 0, never auto-freed
        send_cmd(rcst_pkg::CMD_ALLOC,   6'd0,  1'b1);   // slot 1
        send_cmd(rcst_pkg::CMD_ACQUIRE, 6'd0,  1'b0);
        send_cmd(rcst_pkg::CMD_ACQUIRE, 6'd63, 1'b1);   // unoccupied
        send_cmd(rcst_pkg::CMD_RELEASE, 6'd62, 1'b0);   // unoccupied
        send_cmd(rcst_pkg::CMD_RELEASE, 6'd0,  1'b0);
        send_cmd(rcst_pkg::CMD_RELEASE, 6'd0,  1'b0);   // reaches zero, stays occupied
        send_cmd(rcst_pkg::CMD_RELEASE, 6'd0,  1'b1);   // already at zero
        send_cmd(rcst_pkg::CMD_ACQUIRE, 6'd0,  1'b0);
        send_cmd(rcst_pkg::CMD_RELEASE, 6'd1,  1'b0);   // frees slot 1
        send_cmd(rcst_pkg::CMD_RELEASE, 6'd1,  1'b0);   // now a bad id
        send_cmd(rcst_pkg::cmd_t'(CMD_UNUSED), 6'd63, 1'b1);
        send_cmd(rcst_pkg::CMD_ALLOC,   6'd0,  1'b1);   // reuses slot 1
        send_cmd(rcst_pkg::CMD_ALLOC,   6'd63, 1'b0);   // id ignored
    endtask

    // Allocation window: zero, oversize and small windows, and commands on slots
    // that sit above the window.
    task automatic test_active_window();
        set_active(7'd0);
        send_cmd(rcst_pkg::CMD_ALLOC,   6'd0, 1'b1);
        set_active(7'd127);
        send_cmd(rcst_pkg::CMD_ALLOC,   6'd0, 1'b1);    // slot 3
        set_active(7'd1);
        send_cmd(rcst_pkg::CMD_ALLOC,   6'd0, 1'b1);
        send_cmd(rcst_pkg::CMD_ACQUIRE, 6'd3, 1'b0);
        send_cmd(rcst_pkg::CMD_RELEASE, 6'd3, 1'b0);
        set_active(7'd4);
        send_cmd(rcst_pkg::CMD_ALLOC,   6'd0, 1'b1);
        send_cmd(rcst_pkg::CMD_RELEASE, 6'd3, 1'b0);    // count 1 to 0, auto-release
        send_cmd(rcst_pkg::CMD_ALLOC,   6'd0, 1'b0);
        set_active(rcst_pkg::ACTIVE_SLOTS_RESET);
    endtask

    // Fill every physical slot, overflow with the surplus allocations, then release every live slot.
    task automatic test_fill_table();
        set_active(7'd127);
        repeat (MAX_SLOTS + 1) send_cmd(rcst_pkg::CMD_ALLOC, 6'd0, 1'b1);
        for (int i = 0; i < MAX_SLOTS; i++)
            if (slot_busy[i]) send_cmd(rcst_pkg::CMD_RELEASE, i[SLOT_W-1:0], 1'b0);
        set_active(rcst_pkg::ACTIVE_SLOTS_RESET);
    endtask

    // Run one slot's count up with no idling on either side, then release and acquire it once.
    task automatic test_acquire_burst();
        logic [SLOT_W-1:0] burst_slot;
        wait_drained();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        send_cmd(rcst_pkg::CMD_ALLOC, 6'd0, 1'b1);
        burst_slot = last_predicted.granted_slot;
        repeat (BURST_ITEMS) send_cmd(rcst_pkg::CMD_ACQUIRE, burst_slot, 1'b0);
        send_cmd(rcst_pkg::CMD_RELEASE, burst_slot, 1'b0);
        send_cmd(rcst_pkg::CMD_ACQUIRE, burst_slot, 1'b0);
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    // Hold off the result side for a long stretch while commands keep coming, so the
    // block backs up into its input; then pause the sender until everything drains and send more.
    task automatic test_result_stall();
        wait_drained();
        rx_hold_req = HOLD_CYCLES;
        repeat (16) send_random_cmd();
        wait_drained();
        repeat (16) send_random_cmd();
    endtask

    // Random traffic across several window settings; one phase with no idling at all.
    task automatic test_random_traffic();
        logic [ACT_W-1:0] win;
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0:       win = 7'd64;
                1:       win = 7'd127;
                2:       win = 7'd2;
                3:       win = 7'd0;
                4:       win = 7'd64;
                5:       win = 7'd1;
                6:       win = ACT_W'($urandom_range(3, MAX_SLOTS - 1));
                default: win = ACT_W'($urandom_range(0, 127));
            endcase
            set_active(win);
            tx_idle_en = (p != 4);
            rx_idle_en = (p != 4);
            repeat (PHASE_ITEMS) send_random_cmd();
        end
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Result channel: check each transfer, then pick the next ready.
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string field, input int unsigned exp_v,
                                   input int unsigned act_v);
        mismatch_count++;
        if (reports_left > 0) begin
            reports_left--;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_v, act_v);
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_rsp_q.size() == 0) begin
                mismatch_count++;
                if (reports_left > 0) begin
                    reports_left--;
                    $display("%0t: unexpected result, expected none, actual %h", $time, m_data);
                end
            end else begin
                want = pending_rsp_q.pop_front();
                if (m_data.status !== want.status)
                    report_mismatch("status", want.status, m_data.status);
                if (m_data.granted_slot !== want.granted_slot)
                    report_mismatch("granted_slot", want.granted_slot, m_data.granted_slot);
                if (m_data.count_after !== want.count_after)
                    report_mismatch("count_after", want.count_after, m_data.count_after);
                if (m_data.slot_freed !== want.slot_freed)
                    report_mismatch("slot_freed", want.slot_freed, m_data.slot_freed);
            end
        end
        // Take up a hold-off request; count it down here, not in the sender.
        if (rx_hold_req > 0) begin
            rx_hold_left = rx_hold_req;
            rx_hold_req  = 0;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            m_ready <= 1'b0;
        end else if (rx_idle_en) begin
            m_ready <= ($urandom_range(99) >= RX_IDLE_PCT);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Watchdog: end the run if no transfer happens on either side for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                     $time, STALL_LIMIT, pending_rsp_q.size());
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        active_slots = rcst_pkg::ACTIVE_SLOTS_RESET;
        for (int i = 0; i < MAX_SLOTS; i++) begin
            slot_busy[i]  = 1'b0;
            slot_auto[i]  = 1'b0;
            slot_count[i] = '0;
        end
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // The clearing pass after reset shows up as s_ready held low; the sender waits it out.
        test_slot_lifecycle();
        test_active_window();
        test_fill_table();
        test_acquire_burst();
        test_result_stall();
        test_random_traffic();

        wait_drained();
        repeat (END_SETTLE) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("%0t: %0d mismatches", $time, mismatch_count);
            $display("status: fail");
        end
        $finish;
    end

endmodule

[files.f]
src/rcst_pkg.sv
src/rcst_ram.sv
src/refcounted_slot_table.sv
tb/sv/refcounted_slot_table_tb.sv
